>>> rtl/core/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
package spq_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 7;
    localparam int TOTAL_W  = 32;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 128;

    localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SRCH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd2;

    // Contents of one cell of the sorted row.
    typedef struct packed {
        logic                valid;
        logic [VALUE_W-1:0]  value;
        logic [PRIO_W-1:0]   prio;
    } t_slot;

    // Operation broadcast to every cell; the enables are already qualified.
    typedef struct packed {
        logic                enq;
        logic                deq;
        logic                srch;
        logic [VALUE_W-1:0]  value;
        logic [PRIO_W-1:0]   prio;
    } t_cmd;

endpackage

>>> rtl/core/spq_cell.sv
// One cell of the sorted row: holds one entry and shifts with its neighbors.
module spq_cell #(
    parameter bit HEAD = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  spq_pkg::t_cmd i_cmd,
    input  spq_pkg::t_slot i_prev,
    input  spq_pkg::t_slot i_next,
    input  logic          i_prev_take,
    input  logic          i_hit_before,
    output logic          o_take,
    output logic          o_hit_after,
    output logic          o_first_hit,
    output spq_pkg::t_slot o_slot
);

    logic           r_valid;
    logic [spq_pkg::VALUE_W-1:0] r_value;
    logic [spq_pkg::PRIO_W-1:0]  r_prio;
    logic           r_first_hit;
    logic           n_valid;
    logic [spq_pkg::VALUE_W-1:0] n_value;
    logic [spq_pkg::PRIO_W-1:0]  n_prio;
    logic           w_hit;

    // The head is displaced only by a strictly higher priority; later cells
    // give way to an equal or higher one, so past the head a new entry goes ahead of older ones of equal priority.
    always_comb begin
        if (HEAD) begin
            o_take = !r_valid || (i_cmd.prio > r_prio);
        end else begin
            o_take = !r_valid || (r_prio <= i_cmd.prio);
        end
    end

    assign w_hit       = r_valid && (r_value == i_cmd.value);
    assign o_hit_after = i_hit_before || w_hit;
    assign o_first_hit = r_first_hit;
    assign o_slot      = '{valid: r_valid, value: r_value, prio: r_prio};

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_prio  = r_prio;
        if (i_cmd.enq) begin
            if (i_prev_take) begin
                n_valid = i_prev.valid;
                n_value = i_prev.value;
                n_prio  = i_prev.prio;
            end else if (o_take) begin
                n_valid = 1'b1;
                n_value = i_cmd.value;
                n_prio  = i_cmd.prio;
            end
        end else if (i_cmd.deq) begin
            n_valid = i_next.valid;
            n_value = i_next.value;
            n_prio  = i_next.prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
        if (i_cmd.srch) begin
            r_first_hit <= w_hit && !i_hit_before;
        end
    end

endmodule

>>> rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue built as a row of shifting cells.
//
// The queue holds up to DEPTH (value, priority) entries in a row of cells,
// highest priority in cell 0. Each input transaction on the slave channel
// carries one operation in tuser (enqueue, dequeue or search) and the value
// and priority in tdata. Every operation yields exactly one output
// transaction on the master channel with a status in tuser and the removed
// entry, search hit, head, fill count and comparison total in tdata.
//
// At the accepting edge all cells shift or load in parallel and each cell
// latches whether it holds the first match of a search; in the next cycle
// the match is encoded into an index, the saturating comparison total is
// updated and the result is registered. The block takes no new transaction
// while that encoding step is in progress.
//
// A synchronous reset empties the queue and clears the comparison total;
// cell payloads are not cleared since empty cells are never read. When the
// receiver stalls, the result stays in the output register and no new
// transaction is accepted until that result is taken.
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // item_value [31:0], item_priority [47:32]
    input  logic [spq_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // kind [1:0]
    input  logic [spq_pkg::KIND_W-1:0]     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // out_value [31:0], out_priority [47:32], found [48], head_valid [49],
    // head_value [81:50], fill_count [88:82], compare_total [120:89], zero above
    output logic [spq_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // status [1:0]
    output logic [spq_pkg::STATUS_W-1:0]   o_m_tuser
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int SUM_W = spq_pkg::TOTAL_W;

    logic                          w_accept;
    logic [spq_pkg::KIND_W-1:0]    w_kind;
    logic [spq_pkg::VALUE_W-1:0]   w_value;
    logic [spq_pkg::PRIO_W-1:0]    w_prio;
    logic                          w_full;
    logic                          w_empty;
    spq_pkg::t_cmd                 w_cmd;

    spq_pkg::t_slot                w_slot [DEPTH];
    logic [DEPTH-1:0]              w_take;
    logic [DEPTH-1:0]              w_hit_after;
    logic [DEPTH-1:0]              w_first_hit;

    logic                          r_busy;
    logic                          r_srch;
    logic [spq_pkg::STATUS_W-1:0]  r_status;
    logic [spq_pkg::VALUE_W-1:0]   r_deq_value;
    logic [spq_pkg::PRIO_W-1:0]    r_deq_prio;
    logic [CNT_W-1:0]              r_count;
    logic [SUM_W-1:0]              r_sum;
    logic [SUM_W-1:0]              n_sum;
    logic                          r_out_valid;
    logic [spq_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [spq_pkg::STATUS_W-1:0]  r_out_user;

    logic                          w_found;
    logic [IDX_W-1:0]              w_hit_idx;
    logic [CNT_W-1:0]              w_compares;
    logic [SUM_W:0]                w_sum_wide;
    logic [spq_pkg::STATUS_W-1:0]  n_status;

    // A new operation is taken only when the pipeline step is free and the
    // output register will be empty by the time the result is written.
    assign o_s_tready = !r_busy && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_kind  = i_s_tuser;
    assign w_value = i_s_tdata[spq_pkg::VALUE_W-1:0];
    assign w_prio  = i_s_tdata[spq_pkg::VALUE_W +: spq_pkg::PRIO_W];
    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_cmd.enq   = w_accept && (w_kind == spq_pkg::KIND_ENQ) && !w_full;
        w_cmd.deq   = w_accept && (w_kind == spq_pkg::KIND_DEQ) && !w_empty;
        w_cmd.srch  = w_accept && (w_kind == spq_pkg::KIND_SRCH);
        w_cmd.value = w_value;
        w_cmd.prio  = w_prio;
    end

    always_comb begin
        n_status = spq_pkg::STATUS_OK;
        unique case (w_kind)
            spq_pkg::KIND_ENQ: if (w_full) n_status = spq_pkg::STATUS_OVER;
            spq_pkg::KIND_DEQ: if (w_empty) n_status = spq_pkg::STATUS_UNDER;
            default:           n_status = spq_pkg::STATUS_OK;
        endcase
    end

    // Row of cells; cell 0 is the head. An invalid slot is shifted into the
    // tail on a dequeue.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        spq_pkg::t_slot w_prev;
        spq_pkg::t_slot w_next;
        logic           w_prev_take;
        logic           w_hit_before;

        if (g == 0) begin : g_head
            assign w_prev       = '0;
            assign w_prev_take  = 1'b0;
            assign w_hit_before = 1'b0;
        end else begin : g_body
            assign w_prev       = w_slot[g-1];
            assign w_prev_take  = w_take[g-1];
            assign w_hit_before = w_hit_after[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_slot[g+1];
        end

        spq_cell #(
            .HEAD (g == 0)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_prev       (w_prev),
            .i_next       (w_next),
            .i_prev_take  (w_prev_take),
            .i_hit_before (w_hit_before),
            .o_take       (w_take[g]),
            .o_hit_after  (w_hit_after[g]),
            .o_first_hit  (w_first_hit[g]),
            .o_slot       (w_slot[g])
        );
    end

    // The first-match flags are one-hot, so the index is an OR of the
    // positions of the flagged cells.
    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_first_hit[i]) begin
                w_hit_idx = w_hit_idx | IDX_W'(i);
            end
        end
    end

    assign w_found    = |w_first_hit;
    assign w_compares = w_found ? (CNT_W'(w_hit_idx) + CNT_W'(1)) : r_count;
    assign w_sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(w_compares);

    always_comb begin
        n_sum = r_sum;
        if (r_busy && r_srch) begin
            n_sum = w_sum_wide[SUM_W] ? {SUM_W{1'b1}} : w_sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= w_accept;
            r_sum  <= n_sum;
            if (w_cmd.enq) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_cmd.deq) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Operation context held for the encoding step.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_srch      <= (w_kind == spq_pkg::KIND_SRCH);
            r_status    <= n_status;
            r_deq_value <= w_cmd.deq ? w_slot[0].value : '0;
            r_deq_prio  <= w_cmd.deq ? w_slot[0].prio : '0;
        end
    end

    // Result register; the cells already hold the state after the step.
    // Fields are packed from the lowest bit up, zeros fill the top seven bits.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_out_user <= r_status;
            r_out_data <= spq_pkg::OUT_DATA_W'({
                n_sum,
                spq_pkg::FILL_W'(r_count),
                (w_slot[0].valid ? w_slot[0].value : spq_pkg::VALUE_W'(0)),
                w_slot[0].valid,
                (r_srch && w_found),
                r_deq_prio,
                r_deq_value
            });
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule
